>>> hdl/deadline_event_queue_macros.svh
// Assertion macros for the deadline event queue.
`ifndef DEADLINE_EVENT_QUEUE_MACROS_SVH
`define DEADLINE_EVENT_QUEUE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define DEQ_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define DEQ_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/deq_pkg.sv
package deq_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned RK_W    = 2;

  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ABS   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_AGE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_NOTE  = 3'd5;

  localparam logic [RK_W-1:0] RK_DUE   = 2'd0;
  localparam logic [RK_W-1:0] RK_COUNT = 2'd1;
  localparam logic [RK_W-1:0] RK_AGE   = 2'd2;
  localparam logic [RK_W-1:0] RK_FULL  = 2'd3;

  localparam logic [CNT_W-1:0] PENDING_MAX = 6'd63;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [KIND_W-1:0]  kind_of_event;
    logic [FIELD_W-1:0] time_value;
    logic [FIELD_W-1:0] current_time;
  } deq_in_t;

  typedef struct packed {
    logic [RK_W-1:0]          reply_kind;
    logic [KIND_W-1:0]        reply_type;
    logic [CNT_W-1:0]         pending_count;
    logic                     was_noted;
    logic signed [FIELD_W-1:0] age_seconds;
    logic                     last_of_run;
  } deq_out_t;

endpackage

>>> hdl/deq_cmp_unit.sv
module deq_cmp_unit
  import deq_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0] lhs,
  input  logic [TIME_BITS-1:0] rhs,
  output logic                 le,
  output logic [TIME_BITS-1:0] diff
);
  // One shared subtractor: the borrow gives the unsigned compare.
  logic [TIME_BITS:0] sub;
  assign sub  = {1'b0, rhs} - {1'b0, lhs};
  assign le   = ~sub[TIME_BITS];
  assign diff = sub[TIME_BITS-1:0];
endmodule

>>> hdl/deadline_event_queue.sv
// Channel | Side   | Handshake            | Payload
// in      | input  | in_valid, in_stall   | deq_in_t
// out     | output | out_valid, out_stall | deq_out_t
//
// One item at a time: in_stall is high from the accept edge until the sequencer
// is idle again. Note and ignored items give no result; count, full and age each
// give one. Schedule: entries are compared from the head, entries from the tail
// down are shifted up one slot, then the new entry is inserted. Tick: entries are
// scanned, due results are emitted, kept entries compact. Results hold under out_stall.
// Reset clears occupancy, counts and noted flags; no sweep is needed.
`include "deadline_event_queue_macros.svh"
module deadline_event_queue
  import deq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned TYPE_COUNT  = 16,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  deq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output deq_out_t out_data
);
  localparam int unsigned QI_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TI_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SEARCH, S_SEARCH_RD, S_SHIFT, S_INSERT,
    S_SCAN, S_SCAN_RD, S_EMIT_RD, S_EMIT, S_EMIT_HOLD, S_COMPACT, S_AGE, S_WAIT
  } state_t;

  state_t state;

  // Queue storage, read through a registered port at ptr; shift and compact copy entries directly.
  logic [TIME_BITS-1:0] q_time [QUEUE_DEPTH];
  logic [KIND_W-1:0]    q_kind [QUEUE_DEPTH];
  logic [QC_W-1:0]      occupancy;
  logic [CNT_W-1:0]     type_pending [TYPE_COUNT];
  logic [TIME_BITS-1:0] noted_time [TYPE_COUNT];
  logic [TYPE_COUNT-1:0] noted_valid;

  deq_in_t              item;
  logic [TIME_BITS-1:0] key;
  logic [QC_W-1:0]      ptr;
  logic [QC_W-1:0]      pos;
  logic [QC_W-1:0]      ndue;
  logic [TIME_BITS-1:0] rd_time;
  logic [KIND_W-1:0]    rd_kind;
  logic [TIME_BITS-1:0] noted_rd;
  logic                 noted_ok;

  logic [TIME_BITS-1:0] cmp_lhs;
  logic [TIME_BITS-1:0] cmp_rhs;
  logic                 cmp_le;
  logic [TIME_BITS-1:0] cmp_diff;

  logic [TIME_BITS-1:0] now_t;
  logic [TI_W-1:0]      kidx;
  logic                 kind_ok;
  logic                 emit_last;
  deq_out_t             reply_next;
  logic                 load_out;

  assign now_t     = TIME_BITS'(item.current_time);
  assign kidx      = TI_W'(item.kind_of_event);
  assign kind_ok   = ({28'd0, item.kind_of_event} < TYPE_COUNT);
  assign emit_last = ((ptr + 1'b1) == ndue);
  assign in_stall  = (state != S_IDLE);

  // Shared unit inputs: compare entries against the key in the search and
  // against the current time in the scan, form the age in the age state and
  // the relative deadline (now minus the negated delay) in decode.
  always_comb begin
    unique case (state)
      S_SCAN:   begin cmp_lhs = rd_time;  cmp_rhs = now_t; end
      S_AGE:    begin cmp_lhs = noted_rd; cmp_rhs = now_t; end
      S_DECODE: begin cmp_lhs = ~TIME_BITS'(item.time_value) + 1'b1; cmp_rhs = now_t; end
      default:  begin cmp_lhs = rd_time;  cmp_rhs = key; end
    endcase
  end

  deq_cmp_unit #(.TIME_BITS(TIME_BITS)) u_cmp (
    .lhs (cmp_lhs), .rhs (cmp_rhs), .le (cmp_le), .diff (cmp_diff)
  );

  // Build the result that loads into the output register this cycle.
  always_comb begin
    reply_next = '0;
    reply_next.reply_type  = item.kind_of_event;
    reply_next.last_of_run = 1'b1;
    load_out = 1'b0;
    unique case (state)
      S_DECODE: begin
        if (item.command == CMD_COUNT && kind_ok) begin
          reply_next.reply_kind    = RK_COUNT;
          reply_next.pending_count = type_pending[kidx];
          load_out = 1'b1;
        end else if ((item.command == CMD_ABS || item.command == CMD_REL) && kind_ok
                     && occupancy == QC_W'(QUEUE_DEPTH)) begin
          reply_next.reply_kind = RK_FULL;
          load_out = 1'b1;
        end
      end
      S_AGE: begin
        reply_next.reply_kind  = RK_AGE;
        reply_next.was_noted   = noted_ok;
        reply_next.age_seconds = noted_ok ? signed'(FIELD_W'(cmp_diff)) : '0;
        load_out = 1'b1;
      end
      S_EMIT: begin
        reply_next.reply_kind  = RK_DUE;
        reply_next.reply_type  = rd_kind;
        reply_next.last_of_run = emit_last;
        load_out = 1'b1;
      end
      default: ;
    endcase
  end

  // Registered memory-style reads.
  always_ff @(posedge clk) begin
    rd_time  <= q_time[ptr[QI_W-1:0]];
    rd_kind  <= q_kind[ptr[QI_W-1:0]];
    noted_rd <= noted_time[kidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      occupancy   <= '0;
      noted_valid <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < TYPE_COUNT; i++) type_pending[i] <= '0;
    end else begin
      // A result loads only while the output is empty; drop it once it transfers.
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (load_out) out_data <= reply_next;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            ptr   <= '0;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          // entry 0 is read at this edge and is ready in the next state
          priority if (item.command == CMD_TICK) begin
            ndue  <= '0;
            state <= (occupancy == '0) ? S_IDLE : S_SCAN;
          end else if (item.command > CMD_NOTE || !kind_ok) begin
            state <= S_IDLE;
          end else if (item.command == CMD_ABS || item.command == CMD_REL) begin
            key <= (item.command == CMD_REL) ? cmp_diff : TIME_BITS'(item.time_value);
            pos <= '0;
            if (occupancy == QC_W'(QUEUE_DEPTH)) state <= S_WAIT;
            else if (occupancy == '0) state <= S_INSERT;
            else state <= S_SEARCH;
          end else if (item.command == CMD_COUNT) begin
            state <= S_WAIT;
          end else if (item.command == CMD_AGE) begin
            noted_ok <= noted_valid[kidx];
            state    <= S_AGE;
          end else begin
            noted_time[kidx]  <= now_t;
            noted_valid[kidx] <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_AGE: begin
          state <= S_WAIT;
        end
        S_SEARCH: begin
          // rd_time holds entry pos; advance past entries at or before the key
          if (cmp_le && (pos + 1'b1) < occupancy) begin
            pos   <= pos + 1'b1;
            ptr   <= pos + 1'b1;
            state <= S_SEARCH_RD;
          end else begin
            if (cmp_le) pos <= pos + 1'b1;
            ptr   <= occupancy;
            state <= S_SHIFT;
          end
        end
        S_SEARCH_RD: begin
          state <= S_SEARCH;
        end
        S_SHIFT: begin
          // move entry ptr-1 up to ptr, from the tail down to pos
          if (ptr > pos) begin
            q_time[ptr[QI_W-1:0]] <= q_time[QI_W'(ptr - 1'b1)];
            q_kind[ptr[QI_W-1:0]] <= q_kind[QI_W'(ptr - 1'b1)];
            ptr <= ptr - 1'b1;
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          q_time[pos[QI_W-1:0]] <= key;
          q_kind[pos[QI_W-1:0]] <= item.kind_of_event;
          occupancy <= occupancy + 1'b1;
          if (type_pending[kidx] != PENDING_MAX)
            type_pending[kidx] <= type_pending[kidx] + 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          // rd_time holds entry ndue; count the leading due entries
          if (cmp_le) begin
            ndue <= ndue + 1'b1;
            if ((ndue + 1'b1) < occupancy) begin
              ptr   <= ndue + 1'b1;
              state <= S_SCAN_RD;
            end else begin
              ptr   <= '0;
              state <= S_EMIT_RD;
            end
          end else begin
            ptr   <= '0;
            state <= (ndue == '0) ? S_IDLE : S_EMIT_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN;
        end
        S_EMIT_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          // rd_kind holds entry ptr; its result loads at this edge
          if ({{(32-KIND_W){1'b0}}, rd_kind} < TYPE_COUNT) begin
            if (type_pending[TI_W'(rd_kind)] != '0)
              type_pending[TI_W'(rd_kind)] <= type_pending[TI_W'(rd_kind)] - 1'b1;
          end
          state <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          // hold until the due result transfers, then fetch the next one
          if (out_valid && !out_stall) begin
            if (emit_last) begin
              ptr   <= '0;
              state <= S_COMPACT;
            end else begin
              ptr   <= ptr + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        S_COMPACT: begin
          if (ptr + ndue < occupancy) begin
            q_time[ptr[QI_W-1:0]] <= q_time[QI_W'(ptr + ndue)];
            q_kind[ptr[QI_W-1:0]] <= q_kind[QI_W'(ptr + ndue)];
            ptr <= ptr + 1'b1;
          end else begin
            occupancy <= occupancy - ndue;
            ptr   <= '0;
            state <= S_IDLE;
          end
        end
        S_WAIT: begin
          if (out_valid && !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DEQ_ASSERT_IMP(a_occ_range, clk, rst, 1'b1, occupancy <= QC_W'(QUEUE_DEPTH),
    "occupancy beyond depth")
  `DEQ_ASSERT_IMP(a_busy_stall, clk, rst, state != S_IDLE, in_stall,
    "input taken while busy")
  `DEQ_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid,
    "result dropped under stall")
  `DEQ_ASSERT_NEXT(a_hold_data, clk, rst, out_valid && out_stall, $stable(out_data),
    "result changed under stall")
endmodule
